// File: hdl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_front, wgm_back and the top level in hdl/; depends on nothing.
package wgm_pkg;

  localparam logic [7:0] WILD_ONE = 8'h3F;  // '?'
  localparam logic [7:0] WILD_ANY = 8'h2A;  // '*'

  localparam logic MODE_PAT  = 1'b0;
  localparam logic MODE_SUBJ = 1'b1;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
    logic       last;
    logic       empty_seq;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

endpackage

// File: hdl/wgm_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Generic storage used between the front and back and on the result side; no package use.
module wgm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hdl/wgm_front.sv
// Input front end: accepts transactions and classifies them for the back end.
// Depends on wgm_pkg for the item type.
module wgm_front (
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_mode,
  input  logic [7:0]     in_char_in,
  input  logic           in_last,
  input  logic           in_empty_seq,
  input  logic           mid_full,
  output logic           mid_push,
  output wgm_pkg::item_t mid_item
);

  logic keep;

  // An empty marker without last has no effect at all, so it is dropped here.
  assign keep    = !(in_empty_seq && !in_last);
  assign in_full = mid_full;
  assign mid_push = in_push && !mid_full && keep;

  always_comb begin
    mid_item.mode      = in_mode;
    mid_item.char_in   = in_char_in;
    mid_item.last      = in_last;
    mid_item.empty_seq = in_empty_seq;
  end

endmodule

// File: hdl/wgm_closure.sv
// Star closure of a position set: a reached '*' also reaches the next position.
// Parallel-prefix network, ceil(log2(N)) levels; no package use.
module wgm_closure #(
  parameter int N = 33
) (
  input  logic [N-1:0] set_in,
  input  logic [N-2:0] star,
  output logic [N-1:0] set_out
);

  localparam int LV = $clog2(N);

  logic [N-1:0] g_lv [LV+1];
  logic [N-1:0] p_lv [LV];

  always_comb begin
    int d;
    g_lv[0] = set_in;
    p_lv[0] = {star, 1'b0};
    for (int l = 0; l < LV; l++) begin
      d = 1 << l;
      for (int q = 0; q < N; q++) begin
        if (q >= d) begin
          g_lv[l+1][q] = g_lv[l][q] | (p_lv[l][q] & g_lv[l][q-d]);
        end else begin
          g_lv[l+1][q] = g_lv[l][q];
        end
      end
      if (l + 1 < LV) begin
        for (int q = 0; q < N; q++) begin
          if (q >= d) begin
            p_lv[l+1][q] = p_lv[l][q] & p_lv[l][q-d];
          end else begin
            p_lv[l+1][q] = p_lv[l][q];
          end
        end
      end
    end
  end

  assign set_out = g_lv[LV];

endmodule

// File: hdl/wgm_back.sv
// Back end: pattern store, position-set update and the result stage.
// Depends on wgm_pkg and instantiates wgm_closure twice.
module wgm_back #(
  parameter int PATTERN_MAX = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wgm_pkg::item_t   mid_item,
  input  logic             mid_empty,
  output logic             mid_pop,
  input  logic             out_full,
  output logic             res_push,
  output wgm_pkg::result_t res_data
);

  localparam int N  = PATTERN_MAX + 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [7:0]             pat_r [PATTERN_MAX];
  logic [LW-1:0]          len_r, len_nxt, len_base;
  logic [N-1:0]           reach_r, reach_nxt;
  logic                   ovf_r, ovf_nxt, ovf_base;
  logic                   complete_r, complete_nxt;

  logic                   res_v_r, res_v_nxt;
  logic [N-1:0]           res_set_r;
  logic [PATTERN_MAX-1:0] res_star_r;
  logic [LW-1:0]          res_len_r;
  logic                   res_ovf_r;

  logic [PATTERN_MAX-1:0] star, hit;
  logic [N-1:0]           reach_cl, adv, subj_set, res_cl;
  logic                   stall, take, is_pat, fits, wr_en, capture;

  // Per-lane classification against the current subject byte.
  always_comb begin
    logic lane_on;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      lane_on = (LW'(p) < len_r);
      star[p] = lane_on && (pat_r[p] == wgm_pkg::WILD_ANY);
      hit[p]  = lane_on && (pat_r[p] != wgm_pkg::WILD_ANY) &&
                ((pat_r[p] == wgm_pkg::WILD_ONE) || (pat_r[p] == mid_item.char_in));
    end
  end

  wgm_closure #(.N(N)) u_close (
    .set_in  (reach_r),
    .star    (star),
    .set_out (reach_cl)
  );

  // A star keeps its position; a literal or '?' hit moves one position on.
  always_comb begin
    adv = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (reach_cl[p] && star[p]) begin
        adv[p] = 1'b1;
      end
      if (reach_cl[p] && hit[p]) begin
        adv[p+1] = 1'b1;
      end
    end
  end

  assign stall    = res_v_r && out_full;
  assign mid_pop  = !mid_empty && !stall;
  assign take     = mid_pop;
  assign is_pat   = (mid_item.mode == wgm_pkg::MODE_PAT);
  assign len_base = complete_r ? '0 : len_r;
  assign ovf_base = complete_r ? 1'b0 : ovf_r;
  assign fits     = (len_base < LW'(PATTERN_MAX));
  assign wr_en    = take && is_pat && !mid_item.empty_seq && fits;
  assign subj_set = mid_item.empty_seq ? reach_r : adv;
  assign capture  = take && !is_pat && mid_item.last;

  always_comb begin
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    complete_nxt = complete_r;
    reach_nxt    = reach_r;
    if (take) begin
      if (is_pat) begin
        len_nxt = len_base;
        ovf_nxt = ovf_base;
        if (!mid_item.empty_seq) begin
          if (fits) begin
            len_nxt = len_base + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        complete_nxt = mid_item.last;
        reach_nxt    = N'(1);
      end else begin
        complete_nxt = 1'b1;
        reach_nxt    = mid_item.last ? N'(1) : subj_set;
      end
    end
    res_v_nxt = stall ? res_v_r : capture;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      complete_r <= 1'b1;
      reach_r    <= N'(1);
      res_v_r    <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      complete_r <= complete_nxt;
      reach_r    <= reach_nxt;
      res_v_r    <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (wr_en && (len_base == LW'(p))) begin
        pat_r[p] <= mid_item.char_in;
      end
    end
  end

  // The final closure runs on the registered copy of the set and star mask,
  // so a following pattern load cannot disturb it.
  always_ff @(posedge clk) begin
    if (capture && !stall) begin
      res_set_r  <= subj_set;
      res_star_r <= star;
      res_len_r  <= len_r;
      res_ovf_r  <= ovf_r;
    end
  end

  wgm_closure #(.N(N)) u_res_close (
    .set_in  (res_set_r),
    .star    (res_star_r),
    .set_out (res_cl)
  );

  assign res_push                  = res_v_r && !out_full;
  assign res_data.matched          = res_cl[res_len_r] && !res_ovf_r;
  assign res_data.pattern_overflow = res_ovf_r;

endmodule

// File: hdl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher ('*' and '?').
// Depends on wgm_pkg, wgm_front, wgm_fifo and wgm_back.
//
// Input side is a queue: a transaction is taken when in_push is high and
// in_full is low. Pattern bytes (in_mode 0) are stored until the item with
// in_last; subject bytes (in_mode 1) are matched as they arrive. The item with
// in_last and in_empty_seq marks an empty pattern or subject.
// Result side is a queue: the oldest result is on out_matched and
// out_pattern_overflow while out_empty is low, and it leaves on out_pop.
// One result comes for each subject, after its last byte.
// Throughput: one item per cycle while the result side does not stall, set by the update
// of the position set (one comparator per position and one prefix star closure over the set).
// After the last subject byte is taken, its set is registered in the result stage, where the
// final star closure runs, and the result then passes through the result queue.
// When out_pop is held low the result queue fills, the back end stops
// taking items, the middle queue fills and in_full rises; nothing is lost.
// Reset clears both queues, the pattern length and the overflow flag; the
// pattern bytes themselves are not cleared and there is no clearing pass.
module wildcard_glob_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_mode,
  input  logic [7:0] in_char_in,
  input  logic       in_last,
  input  logic       in_empty_seq,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  localparam int IW = $bits(wgm_pkg::item_t);
  localparam int RW = $bits(wgm_pkg::result_t);

  wgm_pkg::item_t   front_item, mid_item;
  wgm_pkg::result_t res_data, out_data;
  logic             mid_push, mid_full, mid_empty, mid_pop;
  logic             res_push, res_full;
  logic [IW-1:0]    mid_rdata;
  logic [RW-1:0]    out_rdata;

  wgm_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_mode      (in_mode),
    .in_char_in   (in_char_in),
    .in_last      (in_last),
    .in_empty_seq (in_empty_seq),
    .mid_full     (mid_full),
    .mid_push     (mid_push),
    .mid_item     (front_item)
  );

  wgm_fifo #(.W(IW), .DEPTH(wgm_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_item = wgm_pkg::item_t'(mid_rdata);

  wgm_back #(.PATTERN_MAX(PATTERN_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  wgm_fifo #(.W(RW), .DEPTH(wgm_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_data             = wgm_pkg::result_t'(out_rdata);
  assign out_matched          = out_data.matched;
  assign out_pattern_overflow = out_data.pattern_overflow;

  // An overflowed pattern never reports a match.
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pattern_overflow) |-> !out_matched)
    else $error("match reported with pattern overflow");

  // A pattern item never produces a result in the following cycle.
  a_pat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop && (mid_item.mode == wgm_pkg::MODE_PAT)) |=> !res_push)
    else $error("result pushed after a pattern transaction");

  // The result stage only pushes into a queue with room.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

// File: test/wgm_verdict_check.sv
// Checker for the wildcard glob matcher: watches both queue ports, predicts each verdict
// from the accepted items and compares it with what the block returns.
// Depends on wgm_pkg for the wildcard codes, the mode codes and result_t.
module wgm_verdict_check #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic       in_mode,
  input  logic [7:0] in_char_in,
  input  logic       in_last,
  input  logic       in_empty_seq,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic       out_matched,
  input  logic       out_pattern_overflow,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]         pat_bytes [PATTERN_MAX];
  int                 pat_len;
  logic [PATTERN_MAX:0] reach;
  logic               pat_ovf;
  logic               pat_done;
  wgm_pkg::result_t   verdicts [$];
  int                 results_seen;

  // A reached '*' lets the match step past it without consuming a byte. Walking upward
  // lets a run of stars chain in one pass.
  function automatic logic [PATTERN_MAX:0] star_closure(input logic [PATTERN_MAX:0] s);
    int p;
    for (p = 0; p < pat_len; p++) begin
      if (s[p] && pat_bytes[p] == wgm_pkg::WILD_ANY) s[p + 1] = 1'b1;
    end
    return s;
  endfunction

  task automatic take_item(input logic mode, input logic [7:0] ch, input logic last,
                           input logic empty);
    logic [PATTERN_MAX:0] nxt;
    wgm_pkg::result_t     verdict;
    int                   p;
    if (empty && !last) return;
    if (mode == wgm_pkg::MODE_PAT) begin
      if (pat_done) begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        pat_done = 1'b0;
      end
      if (!empty) begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      if (last) pat_done = 1'b1;
      reach = 1;
      return;
    end
    // A subject byte closes any pattern still being loaded.
    pat_done = 1'b1;
    if (!empty) begin
      reach = star_closure(reach);
      nxt   = '0;
      for (p = 0; p < pat_len; p++) begin
        if (reach[p]) begin
          if (pat_bytes[p] == wgm_pkg::WILD_ANY) nxt[p] = 1'b1;
          else if (pat_bytes[p] == wgm_pkg::WILD_ONE || pat_bytes[p] == ch)
            nxt[p + 1] = 1'b1;
        end
      end
      reach = nxt;
    end
    if (last) begin
      reach                    = star_closure(reach);
      verdict.matched          = reach[pat_len] && !pat_ovf;
      verdict.pattern_overflow = pat_ovf;
      verdicts                 = {verdicts, verdict};
      reach = 1;
    end
  endtask

  always @(posedge clk) begin : watch
    wgm_pkg::result_t want;
    if (!rst_n) begin
      pat_len      = 0;
      pat_ovf      = 1'b0;
      pat_done     = 1'b1;
      reach        = 1;
      results_seen = 0;
      fail_count   = 0;
      verdicts.delete();
      pending <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %0d arrived with no subject waiting for it (matched=%0b)",
                     $realtime, results_seen, out_matched);
        end else begin
          want = verdicts.pop_front();
          if (out_matched !== want.matched ||
              out_pattern_overflow !== want.pattern_overflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result %0d expected matched=%0b overflow=%0b, got %0b %0b",
                       $realtime, results_seen, want.matched, want.pattern_overflow,
                       out_matched, out_pattern_overflow);
          end
        end
        results_seen++;
      end
      if (in_push && !in_full) take_item(in_mode, in_char_in, in_last, in_empty_seq);
      pending <= verdicts.size();
    end
  end

endmodule

// File: test/tb_wildcard_glob_matcher.sv
// Top of the wildcard glob matcher testbench: clock, reset, stimulus and the verdict.
// Depends on wgm_pkg, the wildcard_glob_matcher RTL and wgm_verdict_check.
module tb_wildcard_glob_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX = 32;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_X = 8'h78;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_mode;
  logic [7:0] in_char_in;
  logic       in_last;
  logic       in_empty_seq;
  logic       out_empty;
  logic       out_pop;
  logic       out_matched;
  logic       out_pattern_overflow;
  int         fail_count;
  int         pending;

  int         items_sent;
  int         send_count;
  bit         send_quiet;
  bit         burst_on;
  logic [7:0] pat_shadow [$];
  logic [7:0] subj_bytes [$];

  wildcard_glob_matcher #(.PATTERN_MAX(PATTERN_MAX)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_char_in          (in_char_in),
    .in_last             (in_last),
    .in_empty_seq        (in_empty_seq),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_matched         (out_matched),
    .out_pattern_overflow(out_pattern_overflow)
  );

  wgm_verdict_check #(.PATTERN_MAX(PATTERN_MAX)) verdict_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_char_in          (in_char_in),
    .in_last             (in_last),
    .in_empty_seq        (in_empty_seq),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_matched         (out_matched),
    .out_pattern_overflow(out_pattern_overflow),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_wildcard_glob_matcher NOT OK");
    $finish;
  end

  // Mostly a small alphabet so that patterns and subjects meet often; now and then any byte.
  function automatic logic [7:0] subject_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'(CH_A + $urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return wgm_pkg::WILD_ANY;
    if (r == 2) return wgm_pkg::WILD_ONE;
    if (r == 3) return 8'($urandom_range(0, 255));
    return 8'(CH_A + $urandom_range(0, 2));
  endfunction

  function automatic int pattern_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 8);
    if (r == 2) return $urandom_range(PATTERN_MAX - 4, PATTERN_MAX);
    return $urandom_range(1, 6);
  endfunction

  // One transaction on the input queue; the gap before it is drawn per item, with runs of
  // back-to-back items now and then.
  task automatic push_item(input logic mode, input logic [7:0] ch, input logic last,
                           input logic empty);
    int gap;
    if (send_count % 48 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    send_count++;
    gap = (send_quiet || burst_on) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_mode      <= mode;
    in_char_in   <= ch;
    in_last      <= last;
    in_empty_seq <= empty;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!(empty && !last)) items_sent++;
  endtask

  // With cut set the final byte goes out without last, so the pattern is left open.
  task automatic load_pattern(input int len, input bit cut);
    logic [7:0] b;
    int         i;
    pat_shadow.delete();
    if (len == 0) begin
      if (!cut) push_item(wgm_pkg::MODE_PAT, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    for (i = 0; i < len; i++) begin
      b = pattern_byte();
      if (i < PATTERN_MAX) pat_shadow = {pat_shadow, b};
      push_item(wgm_pkg::MODE_PAT, b, !cut && i == len - 1, 1'b0);
    end
  endtask

  // Half the subjects are built from the current pattern so that they reach deep positions,
  // sometimes with one byte spoiled; the rest are random.
  task automatic build_subject();
    int k;
    int n;
    subj_bytes.delete();
    if ($urandom_range(0, 1) == 0 && pat_shadow.size() > 0) begin
      for (k = 0; k < pat_shadow.size(); k++) begin
        if (pat_shadow[k] == wgm_pkg::WILD_ANY)
          repeat ($urandom_range(0, 3)) subj_bytes = {subj_bytes, subject_byte()};
        else if (pat_shadow[k] == wgm_pkg::WILD_ONE) subj_bytes = {subj_bytes, subject_byte()};
        else subj_bytes = {subj_bytes, pat_shadow[k]};
      end
      if ($urandom_range(0, 3) == 0 && subj_bytes.size() > 0)
        subj_bytes[$urandom_range(0, subj_bytes.size() - 1)] = subject_byte();
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
      repeat (n) subj_bytes = {subj_bytes, subject_byte()};
    end
  endtask

  task automatic send_subject(input bit cut);
    int i;
    if (subj_bytes.size() == 0) begin
      if (!cut) push_item(wgm_pkg::MODE_SUBJ, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    for (i = 0; i < subj_bytes.size(); i++) begin
      // Stray empty items without last must be dropped by the block.
      if ($urandom_range(0, 24) == 0)
        push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      push_item(wgm_pkg::MODE_SUBJ, subj_bytes[i], !cut && i == subj_bytes.size() - 1, 1'b0);
    end
  endtask

  // Result side: a random wait before each pop, and one long hold-off while the burst runs.
  initial begin : pop_side
    int  wait_cycles;
    int  pop_count;
    bit  pop_quiet;
    bit  held;
    pop_count = 0;
    pop_quiet = 1'b0;
    held      = 1'b0;
    out_pop  <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pop_count % 48 == 0) pop_quiet = ($urandom_range(0, 3) == 0);
      pop_count++;
      wait_cycles = pop_quiet ? 0 : $urandom_range(0, 10);
      if (burst_on && !held) begin
        held        = 1'b1;
        wait_cycles = 200;
      end
      if (wait_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  initial begin : stimulus
    bit burst_done;
    int r;
    burst_done    = 1'b0;
    items_sent    = 0;
    send_count    = 0;
    send_quiet    = 1'b0;
    burst_on      = 1'b0;
    rst_n        <= 1'b0;
    in_push      <= 1'b0;
    in_mode      <= wgm_pkg::MODE_PAT;
    in_char_in   <= 8'h00;
    in_last      <= 1'b0;
    in_empty_seq <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty subject against the empty pattern left by reset.
    push_item(wgm_pkg::MODE_SUBJ, 8'h00, 1'b1, 1'b1);
    // Empty items without last are ignored in both modes.
    push_item(wgm_pkg::MODE_PAT, 8'hFF, 1'b0, 1'b1);
    push_item(wgm_pkg::MODE_SUBJ, 8'h55, 1'b0, 1'b1);
    // A lone star matches the empty subject and any run of bytes.
    push_item(wgm_pkg::MODE_PAT, wgm_pkg::WILD_ANY, 1'b1, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, 8'hFF, 1'b1, 1'b1);
    push_item(wgm_pkg::MODE_SUBJ, 8'hFF, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, 8'h00, 1'b1, 1'b0);
    // A subject cut short by a new pattern is dropped without a result.
    push_item(wgm_pkg::MODE_SUBJ, CH_A, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_PAT, CH_A, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_PAT, wgm_pkg::WILD_ONE, 1'b1, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, CH_A, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, 8'hFF, 1'b1, 1'b0);
    // A star in the subject is a plain byte.
    push_item(wgm_pkg::MODE_PAT, CH_B, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_PAT, wgm_pkg::WILD_ANY, 1'b1, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, wgm_pkg::WILD_ANY, 1'b1, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, CH_B, 1'b1, 1'b0);
    // Empty pattern against a one-byte subject.
    push_item(wgm_pkg::MODE_PAT, 8'h00, 1'b1, 1'b1);
    push_item(wgm_pkg::MODE_SUBJ, 8'h00, 1'b1, 1'b0);
    // A subject while the pattern is still loading takes the bytes so far as the pattern.
    push_item(wgm_pkg::MODE_PAT, CH_X, 1'b0, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, CH_X, 1'b1, 1'b0);
    push_item(wgm_pkg::MODE_SUBJ, wgm_pkg::WILD_ONE, 1'b1, 1'b0);

    load_pattern(PATTERN_MAX + 1, 1'b0);
    while (items_sent < 920) begin
      if (!burst_done && items_sent >= 400) begin
        // Back-to-back subjects while the result side holds off, then drain completely.
        burst_done = 1'b1;
        burst_on   = 1'b1;
        load_pattern(2, 1'b0);
        repeat (40) push_item(wgm_pkg::MODE_SUBJ, subject_byte(), 1'b1, 1'b0);
        burst_on = 1'b0;
        in_push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 19);
      if (r < 4) begin
        load_pattern(pattern_len(), $urandom_range(0, 9) == 0);
      end else begin
        build_subject();
        send_subject($urandom_range(0, 11) == 0);
      end
    end
    build_subject();
    send_subject(1'b0);

    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_wildcard_glob_matcher OK");
    end else begin
      $display("tb_wildcard_glob_matcher NOT OK");
    end
    $finish;
  end

endmodule
